FILE: src/assert_macros.svh
// Assertion macros shared by the tone mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge while reset is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/esptm_pkg.sv
// Types, codes, constants and tone functions of the sound-port tone mapper.
package esptm_pkg;

   localparam int OP_W    = 3;
   localparam int VALUE_W = 16;
   localparam int CHAN_W  = 2;
   localparam int ACT_W   = 2;
   localparam int HZ_W    = 12;
   localparam int BYTE_W  = 8;
   localparam int SAMPLE_W = 8;
   localparam int LEVEL_W = 2;

   localparam logic [VALUE_W-1:0] FLUSH_CODE   = 16'hFE0C;
   localparam logic [BYTE_W-1:0]  CAS_IN_BYTE  = 8'h80;
   localparam logic [SAMPLE_W-1:0] SAMPLE_FLIP = 8'h80;

   localparam logic [HZ_W-1:0] HZ_LEVEL0   = 12'd520;
   localparam logic [HZ_W-1:0] HZ_LEVEL1   = 12'd880;
   localparam logic [HZ_W-1:0] HZ_LEVEL2   = 12'd660;
   localparam logic [HZ_W-1:0] HZ_LEVEL3   = 12'd1320;
   localparam logic [HZ_W-1:0] HZ_SND_ONE  = 12'd1700;
   localparam logic [HZ_W-1:0] HZ_SND_ZERO = 12'd950;
   localparam logic [HZ_W-1:0] HZ_DAC_BASE = 12'd140;

   typedef enum logic [OP_W-1:0] {
      OP_RESET     = 3'd0,
      OP_MOTOR     = 3'd1,
      OP_CAS_OUT   = 3'd2,
      OP_SOUND_OUT = 3'd3,
      OP_DAC_OUT   = 3'd4,
      OP_DAC_FLUSH = 3'd5,
      OP_REFRESH   = 3'd6,
      OP_CAS_READ  = 3'd7
   } op_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE = 2'd0,
      ACT_STOP = 2'd1,
      ACT_PLAY = 2'd2
   } act_type;

   typedef enum logic [1:0] {
      SND_UNSET = 2'd0,
      SND_ZERO  = 2'd1,
      SND_ONE   = 2'd2
   } snd_type;

   typedef struct packed {
      logic                motor_on;
      logic [LEVEL_W-1:0]  cas_level;
      snd_type             snd;
      logic                cas_in;
      logic [SAMPLE_W-1:0] dac_left;
      logic [SAMPLE_W-1:0] dac_right;
      logic [HZ_W-1:0]     last_left;
      logic [HZ_W-1:0]     last_right;
      logic                known;
   } port_state_type;

   localparam port_state_type RESET_STATE = '{
      motor_on:   1'b0,
      cas_level:  '0,
      snd:        SND_UNSET,
      cas_in:     1'b0,
      dac_left:   '0,
      dac_right:  '0,
      last_left:  '0,
      last_right: '0,
      known:      1'b0
   };

   typedef struct packed {
      act_type           action;
      logic [HZ_W-1:0]   left_hz;
      logic [HZ_W-1:0]   right_hz;
      logic [BYTE_W-1:0] cas_in_byte;
   } rsp_data_type;

   // 140 + v*2600/255 = 140 + 10v + floor(50v/255); the divide by 255 is
   // (x + 1 + (x >> 8)) >> 8, exact for the range of 50v.
   function automatic logic [HZ_W-1:0] dac_to_hz(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] v;
      logic [15:0]         x;
      logic [15:0]         q;
      logic [HZ_W-1:0]     ten_v;
      v     = s ^ SAMPLE_FLIP;
      x     = 16'(16'd50 * {8'd0, v});
      q     = 16'((x + 16'd1 + (x >> 8)) >> 8);
      ten_v = 12'(12'd10 * {4'd0, v});
      return 12'(HZ_DAC_BASE + ten_v + q[HZ_W-1:0]);
   endfunction

   function automatic logic [HZ_W-1:0] level_to_hz(input logic [LEVEL_W-1:0] lv);
      logic [HZ_W-1:0] hz;
      case (lv)
         2'd0:    hz = HZ_LEVEL0;
         2'd1:    hz = HZ_LEVEL1;
         2'd2:    hz = HZ_LEVEL2;
         default: hz = HZ_LEVEL3;
      endcase
      return hz;
   endfunction

endpackage

FILE: src/esptm_ifs.sv
// Handshake channel interfaces of the tone mapper: request, response, register write.
interface esptm_req_if;
   import esptm_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic signed [VALUE_W-1:0] value;
   logic [CHAN_W-1:0]   channels;
   modport source (output valid, operation, value, channels, input ready);
   modport sink   (input valid, operation, value, channels, output ready);
endinterface

interface esptm_rsp_if;
   import esptm_pkg::*;
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [HZ_W-1:0]   left_hz;
   logic [HZ_W-1:0]   right_hz;
   logic [BYTE_W-1:0] cassette_in_byte;
   modport source (output valid, action, left_hz, right_hz, cassette_in_byte, input ready);
   modport sink   (input valid, action, left_hz, right_hz, cassette_in_byte, output ready);
endinterface

interface esptm_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: src/esptm_core.sv
// Port state update and tone selection for one event.
module esptm_core (
   input  logic                         sound_enable,
   input  esptm_pkg::op_type            operation,
   input  logic [esptm_pkg::VALUE_W-1:0] value,
   input  logic [esptm_pkg::CHAN_W-1:0] channels,
   input  esptm_pkg::port_state_type    cur,
   output esptm_pkg::port_state_type    nxt,
   output esptm_pkg::rsp_data_type      result
);
   import esptm_pkg::*;

   port_state_type  upd;
   logic            eval;
   logic            val_nz;
   logic [HZ_W-1:0] tone_l;
   logic [HZ_W-1:0] tone_r;
   logic            last_nz;
   logic            same;
   act_type         act;

   assign val_nz = |value;

   // Apply the port write.
   always_comb begin
      upd  = cur;
      eval = 1'b1;
      case (operation)
         OP_RESET: begin
            upd = RESET_STATE;
         end
         OP_MOTOR: begin
            upd.motor_on = val_nz;
            if (val_nz) upd.cas_in = 1'b0;
         end
         OP_CAS_OUT: begin
            upd.cas_level = value[LEVEL_W-1:0];
            if (cur.motor_on) upd.cas_in = value[0];
         end
         OP_SOUND_OUT: begin
            upd.snd = val_nz ? SND_ONE : SND_ZERO;
         end
         OP_DAC_OUT: begin
            if (value == FLUSH_CODE) begin
               upd.dac_left  = '0;
               upd.dac_right = '0;
            end else begin
               if (channels[0]) upd.dac_left  = value[SAMPLE_W-1:0];
               if (channels[1]) upd.dac_right = value[SAMPLE_W-1:0];
            end
         end
         OP_DAC_FLUSH: begin
            upd.dac_left  = '0;
            upd.dac_right = '0;
         end
         OP_REFRESH: begin
            upd = cur;
         end
         default: begin
            eval = 1'b0;
         end
      endcase
   end

   // Pick the tone pair by priority: motor, DAC, sound bit, cassette level.
   always_comb begin
      if (upd.motor_on) begin
         tone_l = '0;
         tone_r = '0;
      end else if (upd.dac_left != '0 || upd.dac_right != '0) begin
         tone_l = dac_to_hz(upd.dac_left);
         tone_r = dac_to_hz(upd.dac_right);
      end else if (upd.snd != SND_UNSET) begin
         tone_l = (upd.snd == SND_ONE) ? HZ_SND_ONE : HZ_SND_ZERO;
         tone_r = tone_l;
      end else begin
         tone_l = level_to_hz(upd.cas_level);
         tone_r = tone_l;
      end
   end

   assign last_nz = (upd.last_left != '0) || (upd.last_right != '0);
   assign same    = upd.known && tone_l == upd.last_left && tone_r == upd.last_right;

   always_comb begin
      nxt = upd;
      act = ACT_NONE;
      if (eval) begin
         nxt.known = 1'b1;
         if (!sound_enable) begin
            if (!upd.known || last_nz) act = ACT_STOP;
            nxt.last_left  = '0;
            nxt.last_right = '0;
         end else begin
            if (!same) act = (tone_l == '0 && tone_r == '0) ? ACT_STOP : ACT_PLAY;
            nxt.last_left  = tone_l;
            nxt.last_right = tone_r;
         end
      end
   end

   always_comb begin
      result.action      = act;
      result.left_hz     = (act == ACT_PLAY) ? tone_l : '0;
      result.right_hz    = (act == ACT_PLAY) ? tone_r : '0;
      result.cas_in_byte = nxt.cas_in ? CAS_IN_BYTE : '0;
   end

endmodule

FILE: src/emulated_sound_port_tone_mapper_top.sv
// Sound-port tone mapper: port state, output register with skid stage, register port.
// Throughput: one request per cycle while the skid stage is empty; state
// updates at the accepting edge, so back-to-back events see each other. A stalled
// output holds one more result in the skid stage; req_chan.ready stays low until
// the next response beat is taken.
// Reset (synchronous, high): port state cleared, sound_enable set to 1, buffers empty.
`include "assert_macros.svh"

module emulated_sound_port_tone_mapper_top (
   input logic         clock,
   input logic         reset,
   esptm_req_if.sink   req_chan,
   esptm_rsp_if.source rsp_chan,
   esptm_csr_if.sink   csr_chan
);
   import esptm_pkg::*;

   port_state_type state_ff;
   port_state_type state_in;
   logic           sound_enable_ff;
   rsp_data_type   new_data;
   rsp_data_type   out_data_ff;
   rsp_data_type   skid_data_ff;
   logic           out_valid_ff;
   logic           skid_valid_ff;
   logic           accept;
   logic           pop;

   esptm_core u_core (
      .sound_enable (sound_enable_ff),
      .operation    (op_type'(req_chan.operation)),
      .value        (req_chan.value),
      .channels     (req_chan.channels),
      .cur          (state_ff),
      .nxt          (state_in),
      .result       (new_data)
   );

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_enable_ff <= 1'b1;
      end else if (csr_chan.valid && csr_chan.ready) begin
         sound_enable_ff <= csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RESET_STATE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Output register refills from the skid stage first to keep beat order.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : new_data;
      end else if (accept) begin
         skid_data_ff <= new_data;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.action           = out_data_ff.action;
   assign rsp_chan.left_hz          = out_data_ff.left_hz;
   assign rsp_chan.right_hz         = out_data_ff.right_hz;
   assign rsp_chan.cassette_in_byte = out_data_ff.cas_in_byte;

   `ASSERT_CLK(a_skid_needs_out, clock, reset, skid_valid_ff |-> out_valid_ff,
      "skid holds a beat while output register is empty")
   `ASSERT_CLK(a_accept_lands, clock, reset, accept |=> out_valid_ff,
      "accepted beat did not reach the output")
   `ASSERT_CLK(a_play_nonzero, clock, reset,
      (out_valid_ff && out_data_ff.action == ACT_PLAY) |->
      (out_data_ff.left_hz != '0 && out_data_ff.right_hz != '0),
      "play with a zero frequency")
   `ASSERT_CLK(a_noplay_zero, clock, reset,
      (out_valid_ff && out_data_ff.action != ACT_PLAY) |->
      (out_data_ff.left_hz == '0 && out_data_ff.right_hz == '0),
      "frequency given without play")
   `ASSERT_CLK(a_unknown_silent, clock, reset,
      !state_ff.known |-> (state_ff.last_left == '0 && state_ff.last_right == '0),
      "last pair set before any output")

endmodule

FILE: tb/esptm_tone_monitor.sv
`timescale 1ns / 1ps
// Tone mapper monitor: follows port events, predicts each response beat and compares it.
module esptm_tone_monitor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [esptm_pkg::OP_W-1:0]    req_operation,
   input  logic [esptm_pkg::VALUE_W-1:0] req_value,
   input  logic [esptm_pkg::CHAN_W-1:0]  req_channels,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [esptm_pkg::ACT_W-1:0]   rsp_action,
   input  logic [esptm_pkg::HZ_W-1:0]    rsp_left_hz,
   input  logic [esptm_pkg::HZ_W-1:0]    rsp_right_hz,
   input  logic [esptm_pkg::BYTE_W-1:0]  rsp_cassette_in_byte,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_data,
   output int                            mismatches,
   output int                            tones_pending
);
   import esptm_pkg::*;

   port_state_type shadow;
   logic           sound_on;
   rsp_data_type   expected_tones[$];

   function automatic logic [HZ_W-1:0] sample_hz(input logic [SAMPLE_W-1:0] s);
      int unsigned v;
      v = 32'(s ^ SAMPLE_FLIP);
      return HZ_W'(32'(HZ_DAC_BASE) + (v * 2600) / 255);
   endfunction

   function automatic logic [HZ_W-1:0] level_hz(input logic [LEVEL_W-1:0] lv);
      logic [HZ_W-1:0] hz;
      case (lv)
         2'd0:    hz = HZ_LEVEL0;
         2'd1:    hz = HZ_LEVEL1;
         2'd2:    hz = HZ_LEVEL2;
         default: hz = HZ_LEVEL3;
      endcase
      return hz;
   endfunction

   // Update the port state for one event and work out the tone change it causes.
   function automatic rsp_data_type apply_port_event(input logic [OP_W-1:0] op,
                                                     input logic [VALUE_W-1:0] val,
                                                     input logic [CHAN_W-1:0] ch);
      rsp_data_type    r;
      logic [HZ_W-1:0] tone_l;
      logic [HZ_W-1:0] tone_r;
      logic            evaluate;
      r = '{action: ACT_NONE, left_hz: '0, right_hz: '0, cas_in_byte: '0};
      tone_l = '0;
      tone_r = '0;
      evaluate = 1'b1;
      case (op_type'(op))
         OP_RESET: shadow = RESET_STATE;
         OP_MOTOR: begin
            shadow.motor_on = (val != '0);
            if (val != '0)
               shadow.cas_in = 1'b0;
         end
         OP_CAS_OUT: begin
            shadow.cas_level = val[1:0];
            if (shadow.motor_on)
               shadow.cas_in = val[0];
         end
         OP_SOUND_OUT: shadow.snd = (val != '0) ? SND_ONE : SND_ZERO;
         OP_DAC_OUT: begin
            if (val == FLUSH_CODE) begin
               shadow.dac_left  = '0;
               shadow.dac_right = '0;
            end else begin
               if (ch[0])
                  shadow.dac_left = val[SAMPLE_W-1:0];
               if (ch[1])
                  shadow.dac_right = val[SAMPLE_W-1:0];
            end
         end
         OP_DAC_FLUSH: begin
            shadow.dac_left  = '0;
            shadow.dac_right = '0;
         end
         OP_REFRESH: ;
         default: evaluate = 1'b0;
      endcase

      if (evaluate && !sound_on) begin
         // Force silence; stop only if the output is not already known silent.
         if (!shadow.known || shadow.last_left != '0 || shadow.last_right != '0) begin
            r.action          = ACT_STOP;
            shadow.last_left  = '0;
            shadow.last_right = '0;
            shadow.known      = 1'b1;
         end
      end else if (evaluate) begin
         if (!shadow.motor_on) begin
            if (shadow.dac_left != '0 || shadow.dac_right != '0) begin
               tone_l = sample_hz(shadow.dac_left);
               tone_r = sample_hz(shadow.dac_right);
            end else if (shadow.snd != SND_UNSET) begin
               tone_l = (shadow.snd == SND_ONE) ? HZ_SND_ONE : HZ_SND_ZERO;
               tone_r = tone_l;
            end else begin
               tone_l = level_hz(shadow.cas_level);
               tone_r = tone_l;
            end
         end
         if (!(shadow.known && tone_l == shadow.last_left && tone_r == shadow.last_right))
         begin
            if (tone_l == '0 && tone_r == '0) begin
               r.action = ACT_STOP;
            end else begin
               r.action   = ACT_PLAY;
               r.left_hz  = tone_l;
               r.right_hz = tone_r;
            end
            shadow.last_left  = tone_l;
            shadow.last_right = tone_r;
            shadow.known      = 1'b1;
         end
      end
      r.cas_in_byte = shadow.cas_in ? CAS_IN_BYTE : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      // Keep the log short on a badly broken block; keep counting regardless.
      if (mismatches < 100)
         $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         shadow   = RESET_STATE;
         sound_on = 1'b1;
         expected_tones.delete();
      end else begin
         if (csr_valid && csr_ready)
            sound_on = csr_data;
         if (req_valid && req_ready)
            expected_tones.push_back(apply_port_event(req_operation, req_value, req_channels));
         if (rsp_valid && rsp_ready) begin
            if (expected_tones.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = expected_tones.pop_front();
               if (rsp_action != want.action)
                  report_mismatch($sformatf("action got %0d expected %0d",
                                            rsp_action, want.action));
               if (rsp_left_hz != want.left_hz)
                  report_mismatch($sformatf("left_hz got %0d expected %0d",
                                            rsp_left_hz, want.left_hz));
               if (rsp_right_hz != want.right_hz)
                  report_mismatch($sformatf("right_hz got %0d expected %0d",
                                            rsp_right_hz, want.right_hz));
               if (rsp_cassette_in_byte != want.cas_in_byte)
                  report_mismatch($sformatf("cassette_in_byte got 'h%0h expected 'h%0h",
                                            rsp_cassette_in_byte, want.cas_in_byte));
            end
         end
      end
      tones_pending = expected_tones.size();
   end

endmodule

FILE: tb/emulated_sound_port_tone_mapper_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the tone mapper: clock, reset, stimulus, receiver stalls and verdict.
module emulated_sound_port_tone_mapper_top_tb;
   import esptm_pkg::*;

   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;

   esptm_req_if req_chan ();
   esptm_rsp_if rsp_chan ();
   esptm_csr_if csr_chan ();

   int mismatches;
   int tones_pending;
   int idle_pct;
   int stall_pct;
   bit hold_req;
   bit hold_ack;
   int hold_left;

   emulated_sound_port_tone_mapper_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   esptm_tone_monitor u_tone_monitor (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_chan.valid),
      .req_ready            (req_chan.ready),
      .req_operation        (req_chan.operation),
      .req_value            (req_chan.value),
      .req_channels         (req_chan.channels),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_action           (rsp_chan.action),
      .rsp_left_hz          (rsp_chan.left_hz),
      .rsp_right_hz         (rsp_chan.right_hz),
      .rsp_cassette_in_byte (rsp_chan.cassette_in_byte),
      .csr_valid            (csr_chan.valid),
      .csr_ready            (csr_chan.ready),
      .csr_data             (csr_chan.data),
      .mismatches           (mismatches),
      .tones_pending        (tones_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_chan.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_event(input op_type op, input logic [VALUE_W-1:0] val,
                             input logic [CHAN_W-1:0] ch);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.value     <= val;
      req_chan.channels  <= ch;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_tones();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tones_pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic set_sound_enable(input logic en);
      drain_tones();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= en;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   // Weighted toward sequences that move the tone priority around.
   task automatic random_event();
      op_type             op;
      logic [VALUE_W-1:0] val;
      logic [CHAN_W-1:0]  ch;
      int                 pick;
      pick = $urandom_range(99);
      val  = 16'($urandom);
      ch   = 2'($urandom_range(3));
      if (pick < 4) begin
         op = OP_RESET;
      end else if (pick < 14) begin
         op = OP_MOTOR;
         if ($urandom_range(9) < 6)
            val = '0;
      end else if (pick < 28) begin
         op = OP_CAS_OUT;
      end else if (pick < 40) begin
         op = OP_SOUND_OUT;
         if ($urandom_range(3) == 0)
            val = '0;
      end else if (pick < 64) begin
         op = OP_DAC_OUT;
         case ($urandom_range(9))
            0:       val = FLUSH_CODE;
            1:       val[7:0] = 8'h00;
            2:       val[7:0] = SAMPLE_FLIP;
            default: ;
         endcase
      end else if (pick < 74) begin
         op = OP_DAC_FLUSH;
      end else if (pick < 86) begin
         op = OP_REFRESH;
      end else begin
         op = OP_CAS_READ;
      end
      send_event(op, val, ch);
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) random_event();
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_REFRESH;
      req_chan.value     <= '0;
      req_chan.channels  <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.data      <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      hold_req  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: cassette levels, sound bit, DAC extremes, motor, reset, disable.
      send_event(OP_CAS_READ, 16'h0000, 2'b00);
      send_event(OP_REFRESH, 16'h0000, 2'b00);
      send_event(OP_CAS_OUT, 16'hFFFD, 2'b11);
      send_event(OP_CAS_OUT, 16'h0002, 2'b00);
      send_event(OP_CAS_OUT, 16'h0003, 2'b00);
      send_event(OP_SOUND_OUT, 16'h0000, 2'b00);
      send_event(OP_SOUND_OUT, 16'h8000, 2'b00);
      send_event(OP_REFRESH, 16'h7FFF, 2'b11);
      send_event(OP_DAC_OUT, 16'h0080, 2'b01);
      send_event(OP_DAC_OUT, 16'h7FFF, 2'b11);
      send_event(OP_DAC_OUT, 16'h007F, 2'b10);
      send_event(OP_DAC_OUT, 16'hABCD, 2'b00);
      send_event(OP_DAC_OUT, FLUSH_CODE, 2'b11);
      send_event(OP_DAC_OUT, 16'h0042, 2'b01);
      send_event(OP_DAC_FLUSH, 16'h0000, 2'b00);
      send_event(OP_MOTOR, 16'h0001, 2'b00);
      send_event(OP_CAS_OUT, 16'h0003, 2'b00);
      send_event(OP_CAS_READ, 16'h0000, 2'b00);
      send_event(OP_MOTOR, 16'h8000, 2'b00);
      send_event(OP_CAS_OUT, 16'h0001, 2'b00);
      send_event(OP_MOTOR, 16'h0000, 2'b00);
      send_event(OP_RESET, 16'h0000, 2'b00);
      set_sound_enable(1'b0);
      send_event(OP_REFRESH, 16'h0000, 2'b00);
      send_event(OP_SOUND_OUT, 16'h0001, 2'b00);
      send_event(OP_RESET, 16'h0000, 2'b00);
      set_sound_enable(1'b1);
      send_event(OP_REFRESH, 16'h0000, 2'b00);

      run_phase(0, 0, 150);
      run_phase(59, 0, 150);
      run_phase(0, 59, 150);
      run_phase(30, 30, 150);

      // Hold off the response side while requests keep coming, so the input backs up.
      idle_pct  = 0;
      stall_pct = 0;
      hold_req  = ~hold_req;
      repeat (50) random_event();

      set_sound_enable(1'b0);
      run_phase(30, 30, 60);
      set_sound_enable(1'b1);
      run_phase(0, 0, 100);
      set_sound_enable(1'b0);
      run_phase(59, 59, 20);
      set_sound_enable(1'b1);
      run_phase(30, 30, 40);

      drain_tones();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && tones_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/esptm_pkg.sv
src/esptm_ifs.sv
src/esptm_core.sv
src/emulated_sound_port_tone_mapper_top.sv
tb/esptm_tone_monitor.sv
tb/emulated_sound_port_tone_mapper_top_tb.sv
